// ===== hw/rtl/itbt_pkg.sv =====
// ----------------------------------------------------------------------------
// itbt_pkg: shared types and constants for integer_to_base_text
// Microcode word layout, branch conditions, the control store contents,
// ASCII constants and the digit-to-character map.
// ----------------------------------------------------------------------------
package itbt_pkg;

	// Datapath sizing
	localparam int WORD_BITS  = 32;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int CNT_W      = $clog2(WORD_BITS + 1);
	localparam int ADDR_W     = $clog2(WORD_BITS);
	// Divider retires DIV_BITS quotient bits per cycle
	localparam int DIV_BITS   = 4;
	localparam int DIV_STEPS  = WORD_BITS / DIV_BITS;
	localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// Radix register limits
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = RADIX_W'(9);
	localparam logic [RADIX_W-1:0] DIGIT_TEN     = RADIX_W'(10);

	// Sequencer program counter
	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	// Control store addresses
	localparam upc_t UA_IDLE  = UPC_W'(0);
	localparam upc_t UA_DIV   = UPC_W'(1);
	localparam upc_t UA_TEST  = UPC_W'(2);
	localparam upc_t UA_SIGN  = UPC_W'(3);
	localparam upc_t UA_MINUS = UPC_W'(4);
	localparam upc_t UA_READ  = UPC_W'(5);
	localparam upc_t UA_EMIT  = UPC_W'(6);
	localparam upc_t UA_LOOP  = UPC_W'(7);
	localparam upc_t UA_DONE  = UPC_W'(8);

	// Branch conditions
	typedef enum logic [2:0] {
		COND_NONE     = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_IN_VALID = 3'd2,
		COND_DIV_LAST = 3'd3,
		COND_Q_ZERO   = 3'd4,
		COND_NEG      = 3'd5,
		COND_CNT_ZERO = 3'd6,
		COND_OUT_FREE = 3'd7
	} cond_t;

	// One microcode word
	typedef struct packed {
		logic  in_take;     // input channel open, load on transfer
		logic  div;         // one divider iteration
		logic  rd;          // read digit store at count - 1
		logic  emit_sign;   // offer '-' to the output register
		logic  emit_digit;  // offer the read digit to the output register
		cond_t cond;
		logic  inv;         // branch when condition is false
		upc_t  target;
	} cw_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic div_last;
		logic q_zero;
		logic neg;
		logic cnt_zero;
	} dp_stat_t;

	localparam cw_t CW_NOP = '{
		in_take: 1'b0, div: 1'b0, rd: 1'b0, emit_sign: 1'b0, emit_digit: 1'b0,
		cond: COND_NONE, inv: 1'b0, target: UA_IDLE
	};

	// Control store
	function automatic cw_t ucode(input upc_t a);
		cw_t w;
		w = CW_NOP;
		case (a)
			UA_IDLE: begin
				// wait for an input transfer
				w.in_take = 1'b1;
				w.cond    = COND_IN_VALID;
				w.inv     = 1'b1;
				w.target  = UA_IDLE;
			end
			UA_DIV: begin
				w.div    = 1'b1;
				w.cond   = COND_DIV_LAST;
				w.inv    = 1'b1;
				w.target = UA_DIV;
			end
			UA_TEST: begin
				// more digits while quotient is nonzero
				w.cond   = COND_Q_ZERO;
				w.inv    = 1'b1;
				w.target = UA_DIV;
			end
			UA_SIGN: begin
				w.cond   = COND_NEG;
				w.inv    = 1'b1;
				w.target = UA_READ;
			end
			UA_MINUS: begin
				w.emit_sign = 1'b1;
				w.cond      = COND_OUT_FREE;
				w.inv       = 1'b1;
				w.target    = UA_MINUS;
			end
			UA_READ: begin
				w.rd = 1'b1;
			end
			UA_EMIT: begin
				w.emit_digit = 1'b1;
				w.cond       = COND_OUT_FREE;
				w.inv        = 1'b1;
				w.target     = UA_EMIT;
			end
			UA_LOOP: begin
				w.cond   = COND_CNT_ZERO;
				w.inv    = 1'b1;
				w.target = UA_READ;
			end
			UA_DONE: begin
				w.cond   = COND_ALWAYS;
				w.target = UA_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = UA_IDLE;
			end
		endcase
		return w;
	endfunction

	// Digit value to lower-case ASCII
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d <= DIGIT_MAX_DEC) begin
			c = CHAR_W'(CH_ZERO + CHAR_W'(d));
		end else begin
			c = CHAR_W'(CH_A + CHAR_W'(d - DIGIT_TEN));
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/integer_to_base_text.sv =====
// ----------------------------------------------------------------------------
// integer_to_base_text: signed integer to ASCII text in a programmable base
// Microcoded converter: sequencer, divider datapath and output register.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_stall, value): one signed 32-bit integer per
//   transfer. in_stall is low only while the converter waits for a number.
//   Output channel (out_valid/out_stall, char_code, last_char): one ASCII
//   character per transfer, most significant first, '-' first for negative
//   values; last_char marks the final character of each number.
//   Config channel (cfg_valid/cfg_ready, radix): cfg_ready is always high;
//   writes are clamped to 2..36 and must only be made while idle.
// Steps
//   A number runs through divider iterations (4 quotient bits per cycle) and
//   a zero test per digit, then a sign test, a '-' emit step for negative
//   values, a read/emit/branch loop per character, and end and wait steps.
// Reset
//   arst_n clears the sequencer to its wait step, empties the output
//   register and sets the radix to 10.
// Stall
//   A stalled output holds its character; the sequencer waits on that emit
//   step and takes no new number until the last character is registered.
// ----------------------------------------------------------------------------
module integer_to_base_text (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input number
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [itbt_pkg::WORD_BITS-1:0] value,
	// output characters
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [itbt_pkg::CHAR_W-1:0]           char_code,
	output logic                                  last_char,
	// radix register write
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [itbt_pkg::RADIX_W-1:0]          radix
);

	itbt_pkg::cw_t                cw;
	itbt_pkg::dp_stat_t           stat;
	logic [itbt_pkg::RADIX_W-1:0] radix_q;
	logic [itbt_pkg::CHAR_W-1:0]  emit_char;
	logic                         emit_last;
	logic                         out_valid_q;
	logic [itbt_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;
	logic                         out_free;
	logic                         emit_fire;

	// Radix register, clamped on write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itbt_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (radix < itbt_pkg::RADIX_MIN) begin
				radix_q <= itbt_pkg::RADIX_MIN;
			end else if (radix > itbt_pkg::RADIX_MAX) begin
				radix_q <= itbt_pkg::RADIX_MAX;
			end else begin
				radix_q <= radix;
			end
		end
	end

	// Sequencer
	itbt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.cw       (cw)
	);

	// Datapath
	itbt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.in_valid  (in_valid),
		.out_free  (out_free),
		.value     (value),
		.radix_cur (radix_q),
		.stat      (stat),
		.emit_char (emit_char),
		.emit_last (emit_last)
	);

	assign in_stall = !cw.in_take;

	// Output register
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_fire = (cw.emit_sign || cw.emit_digit) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	// Checks
	a_take_not_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(!in_stall && emit_fire))
		else $error("input taken while a character is emitted");

	a_one_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input channel open right after a transfer");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_char) |-> (char_code != itbt_pkg::CH_MINUS))
		else $error("sign character marked as last");

endmodule

// ===== hw/rtl/itbt_seq.sv =====
// ----------------------------------------------------------------------------
// itbt_seq: microcode sequencer
// Step counter, control store fetch and conditional branch selection.
// ----------------------------------------------------------------------------
module itbt_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  itbt_pkg::dp_stat_t stat,
	output itbt_pkg::cw_t     cw
);

	itbt_pkg::upc_t upc_q;
	logic           cond_val;
	logic           take_branch;

	// Fetch
	assign cw = itbt_pkg::ucode(upc_q);

	// Condition select
	always_comb begin
		case (cw.cond)
			itbt_pkg::COND_NONE:     cond_val = 1'b0;
			itbt_pkg::COND_ALWAYS:   cond_val = 1'b1;
			itbt_pkg::COND_IN_VALID: cond_val = in_valid;
			itbt_pkg::COND_DIV_LAST: cond_val = stat.div_last;
			itbt_pkg::COND_Q_ZERO:   cond_val = stat.q_zero;
			itbt_pkg::COND_NEG:      cond_val = stat.neg;
			itbt_pkg::COND_CNT_ZERO: cond_val = stat.cnt_zero;
			itbt_pkg::COND_OUT_FREE: cond_val = out_free;
			default:                 cond_val = 1'b0;
		endcase
	end

	assign take_branch = cond_val ^ cw.inv;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= itbt_pkg::UA_IDLE;
		end else if (take_branch) begin
			upc_q <= cw.target;
		end else begin
			upc_q <= itbt_pkg::UPC_W'(upc_q + 1'b1);
		end
	end

endmodule

// ===== hw/rtl/itbt_dp.sv =====
// ----------------------------------------------------------------------------
// itbt_dp: conversion datapath
// Magnitude register with a radix divider (several quotient bits per cycle),
// digit store, digit count and sign flag, driven by the microcode word.
// ----------------------------------------------------------------------------
module itbt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  itbt_pkg::cw_t                        cw,
	input  logic                                 in_valid,
	input  logic                                 out_free,
	input  logic signed [itbt_pkg::WORD_BITS-1:0] value,
	input  logic [itbt_pkg::RADIX_W-1:0]         radix_cur,
	output itbt_pkg::dp_stat_t                   stat,
	output logic [itbt_pkg::CHAR_W-1:0]          emit_char,
	output logic                                 emit_last
);

	logic [itbt_pkg::WORD_BITS-1:0] mag_q;
	logic [itbt_pkg::RADIX_W-1:0]   rem_q;
	logic [itbt_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [itbt_pkg::CNT_W-1:0]     cnt_q;
	logic                           neg_q;
	logic [itbt_pkg::RADIX_W-1:0]   rdata_q;
	logic [itbt_pkg::RADIX_W-1:0]   digit_mem [itbt_pkg::WORD_BITS];

	logic [itbt_pkg::WORD_BITS-1:0] val_u;
	logic [itbt_pkg::WORD_BITS-1:0] mag_in;
	logic [itbt_pkg::WORD_BITS-1:0] mag_nxt;
	logic [itbt_pkg::RADIX_W-1:0]   rem_nxt;
	logic [itbt_pkg::RADIX_W:0]     trial;
	logic                           load_fire;
	logic                           digit_done;
	logic                           digit_fire;
	logic [itbt_pkg::ADDR_W-1:0]    rd_addr;

	// Magnitude as unsigned, most negative value included
	assign val_u  = value;
	assign mag_in = val_u[itbt_pkg::WORD_BITS-1] ? itbt_pkg::WORD_BITS'(~val_u + 1'b1) : val_u;

	assign load_fire  = cw.in_take && in_valid;
	assign stat.div_last = (div_cnt_q == itbt_pkg::DIV_CNT_W'(itbt_pkg::DIV_STEPS - 1));
	assign digit_done = cw.div && stat.div_last;
	assign digit_fire = cw.emit_digit && out_free;
	assign rd_addr    = itbt_pkg::ADDR_W'(cnt_q - 1'b1);

	assign stat.q_zero   = (mag_q == '0);
	assign stat.neg      = neg_q;
	assign stat.cnt_zero = (cnt_q == '0);

	// Restoring division, DIV_BITS quotient bits per iteration
	always_comb begin
		rem_nxt = rem_q;
		mag_nxt = mag_q;
		trial   = '0;
		for (int i = 0; i < itbt_pkg::DIV_BITS; i++) begin
			trial   = {rem_nxt, mag_nxt[itbt_pkg::WORD_BITS-1]};
			mag_nxt = {mag_nxt[itbt_pkg::WORD_BITS-2:0], 1'b0};
			if (trial >= {1'b0, radix_cur}) begin
				rem_nxt    = itbt_pkg::RADIX_W'(trial - {1'b0, radix_cur});
				mag_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[itbt_pkg::RADIX_W-1:0];
			end
		end
	end

	// Control and magnitude registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
		end else if (load_fire) begin
			mag_q     <= mag_in;
			rem_q     <= '0;
			div_cnt_q <= '0;
			cnt_q     <= '0;
			neg_q     <= val_u[itbt_pkg::WORD_BITS-1];
		end else if (cw.div) begin
			mag_q <= mag_nxt;
			if (digit_done) begin
				rem_q     <= '0;
				div_cnt_q <= '0;
				cnt_q     <= itbt_pkg::CNT_W'(cnt_q + 1'b1);
			end else begin
				rem_q     <= rem_nxt;
				div_cnt_q <= itbt_pkg::DIV_CNT_W'(div_cnt_q + 1'b1);
			end
		end else if (digit_fire) begin
			cnt_q <= itbt_pkg::CNT_W'(cnt_q - 1'b1);
		end
	end

	// Digit store: written as each digit completes, read back in reverse
	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem[cnt_q[itbt_pkg::ADDR_W-1:0]] <= rem_nxt;
		end
		if (cw.rd) begin
			rdata_q <= digit_mem[rd_addr];
		end
	end

	// Character offered to the output register
	assign emit_char = cw.emit_sign ? itbt_pkg::CH_MINUS : itbt_pkg::digit_char(rdata_q);
	assign emit_last = cw.emit_digit && (cnt_q == itbt_pkg::CNT_W'(1));

endmodule

// ===== tb/itbt_checker.sv =====
// ----------------------------------------------------------------------------
// itbt_checker: output checker for integer_to_base_text
// Watches the number, character and radix channels. Every accepted number is
// spelled out in the current radix and queued; every character transfer is
// compared with the oldest queued character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itbt_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [itbt_pkg::WORD_BITS-1:0] value,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [itbt_pkg::CHAR_W-1:0]           char_code,
	input  logic                                  last_char,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [itbt_pkg::RADIX_W-1:0]          radix,
	output int                                    mismatches,
	output int                                    pending
);

	typedef struct packed {
		logic [itbt_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_char_t;

	text_char_t                   owed_chars[$];
	logic [itbt_pkg::RADIX_W-1:0] cur_radix   = itbt_pkg::RADIX_RESET;
	int                           fault_count = 0;
	int                           owed_count  = 0;

	assign mismatches = fault_count;
	assign pending    = owed_count;

	// Spell one number in the given base and queue its characters
	function automatic void spell_number(input logic [itbt_pkg::WORD_BITS-1:0] word,
		input logic [itbt_pkg::RADIX_W-1:0] base);
		logic [itbt_pkg::WORD_BITS-1:0] mag;
		logic [itbt_pkg::RADIX_W-1:0]   digits [itbt_pkg::WORD_BITS];
		logic [itbt_pkg::RADIX_W-1:0]   d;
		logic [itbt_pkg::CHAR_W-1:0]    c;
		logic                           neg;
		int                             count;
		int                             k;
		neg   = word[itbt_pkg::WORD_BITS-1];
		// unsigned magnitude, so the most negative value converts correctly
		mag   = neg ? (~word + 1'b1) : word;
		count = 0;
		do begin
			digits[count] = itbt_pkg::RADIX_W'(mag % base);
			count++;
			mag = mag / base;
		end while (mag != '0);
		if (neg) begin
			owed_chars.push_back('{code: itbt_pkg::CH_MINUS, last: 1'b0});
		end
		for (k = count - 1; k >= 0; k--) begin
			d = digits[k];
			if (d < itbt_pkg::DIGIT_TEN) begin
				c = itbt_pkg::CH_ZERO + itbt_pkg::CHAR_W'(d);
			end else begin
				c = itbt_pkg::CH_A + itbt_pkg::CHAR_W'(d - itbt_pkg::DIGIT_TEN);
			end
			owed_chars.push_back('{code: c, last: (k == 0)});
		end
	endfunction

	// Compare character transfers, then queue new numbers, then track radix
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (owed_chars.size() == 0) begin
					if (fault_count < 10) begin
						$display("[%0t] unexpected character %h last %b",
							$realtime, char_code, last_char);
					end
					fault_count++;
				end else begin
					want = owed_chars.pop_front();
					if (want.code !== char_code || want.last !== last_char) begin
						if (fault_count < 10) begin
							$display("[%0t] char mismatch: expected %h last %b, got %h last %b",
								$realtime, want.code, want.last, char_code, last_char);
						end
						fault_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				spell_number(value, cur_radix);
			end
			// radix writes are clamped to the legal range
			if (cfg_valid && cfg_ready) begin
				if (radix < itbt_pkg::RADIX_MIN) begin
					cur_radix <= itbt_pkg::RADIX_MIN;
				end else if (radix > itbt_pkg::RADIX_MAX) begin
					cur_radix <= itbt_pkg::RADIX_MAX;
				end else begin
					cur_radix <= radix;
				end
			end
		end
		owed_count <= owed_chars.size();
	end

endmodule

// ===== tb/tb_integer_to_base_text.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_base_text: testbench for integer_to_base_text
// Sends directed and random signed numbers under several radix settings,
// with random gaps on the number channel and random stalls on the character
// channel. The checker predicts the text and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_base_text;

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 46;
	localparam int DRAIN_LIMIT   = 20000;

	logic                                  clk       = 1'b0;
	logic                                  arst_n    = 1'b0;
	logic                                  in_valid  = 1'b0;
	logic                                  in_stall;
	logic signed [itbt_pkg::WORD_BITS-1:0] value     = '0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic [itbt_pkg::CHAR_W-1:0]           char_code;
	logic                                  last_char;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [itbt_pkg::RADIX_W-1:0]          radix     = itbt_pkg::RADIX_RESET;

	int mismatches;
	int pending;
	int stall_pct  = 0;
	int stall_left = 0;
	int gap_pct    = 0;
	int cur_base   = 10;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	integer_to_base_text dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.radix     (radix)
	);

	itbt_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.radix      (radix),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Idle length: mostly short, now and then long
	function automatic int idle_length();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(8, 20);
		end
		return $urandom_range(1, 3);
	endfunction

	// Number shaped to hit digit boundaries of the current base
	function automatic logic [itbt_pkg::WORD_BITS-1:0] pick_number(input int base);
		logic [63:0] pw;
		logic [31:0] v;
		int          k;
		case ($urandom_range(9))
			0, 1, 2: v = $urandom();
			3, 4:    v = $urandom_range(0, 99);
			5:       v = -$urandom_range(1, 99);
			6: begin
				pw = 64'd1;
				k  = $urandom_range(1, 31);
				repeat (k) begin
					if (pw * base <= 64'h8000_0000) pw = pw * base;
				end
				v = 32'(pw) - $urandom_range(0, 1);
				if ($urandom_range(1)) v = -v;
			end
			7: begin
				case ($urandom_range(4))
					0:       v = 32'h7FFF_FFFF;
					1:       v = 32'h8000_0000;
					2:       v = 32'h8000_0001;
					3:       v = 32'hFFFF_FFFF;
					default: v = 32'h0000_0000;
				endcase
			end
			default: begin
				v = $urandom() >> $urandom_range(0, 31);
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	// One number transfer, after an optional gap
	task automatic send_number(input logic [itbt_pkg::WORD_BITS-1:0] num);
		int gap;
		gap = ($urandom_range(99) < gap_pct) ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= num;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold off until every queued character has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		do @(posedge clk); while (pending != 0 || in_stall);
	endtask

	// Radix write, only with the converter idle
	task automatic set_radix(input logic [itbt_pkg::RADIX_W-1:0] r);
		wait_drained();
		cfg_valid <= 1'b1;
		radix     <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_base = (r < itbt_pkg::RADIX_MIN) ? 2 :
			((r > itbt_pkg::RADIX_MAX) ? 36 : int'(r));
	endtask

	// Character channel stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < stall_pct) begin
			out_stall  <= 1'b1;
			stall_left <= idle_length() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// Stimulus
	initial begin
		int phase;
		int waited;
		logic [itbt_pkg::RADIX_W-1:0] r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal after reset: zero, signs, extremes
		send_number(32'h0000_0000);
		send_number(32'hFFFF_FFFF);
		send_number(32'h0000_0001);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'd123456789);
		send_number(-32'sd987654321);
		send_number(32'd10);

		// base 36: top letter digit and its carry
		set_radix(6'd36);
		stall_pct <= 30;
		gap_pct = 30;
		send_number(32'd35);
		send_number(32'd36);
		send_number(-32'sd35);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'h0000_0000);

		// base 2: longest text
		set_radix(6'd2);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		send_number(32'hFFFF_FFFF);
		send_number(32'd5);

		// random phases, out-of-range radix writes among them
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       r = 6'd16;
				1:       r = 6'd0;
				2:       r = 6'd63;
				3:       r = 6'd8;
				4:       r = 6'd1;
				5:       r = 6'd37;
				default: r = 6'($urandom_range(0, 63));
			endcase
			set_radix(r);
			case (phase % 3)
				0: begin
					stall_pct <= 0;
					gap_pct = 0;
				end
				1: begin
					stall_pct <= 25;
					gap_pct = 25;
				end
				default: begin
					stall_pct <= 60;
					gap_pct = 50;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(39) == 0) wait_drained();
				send_number(pick_number(cur_base));
			end
		end
		in_valid <= 1'b0;

		// drain once the last number is counted, then let the bench settle
		@(posedge clk);
		waited = 0;
		while ((pending != 0 || in_stall) && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
